[src/lexicographic_cost_quantize_pack_unit_assert.svh]
// Assertion macros shared by the checker of the cost quantize and pack unit.
`ifndef LEXICOGRAPHIC_COST_QUANTIZE_PACK_UNIT_ASSERT_SVH
`define LEXICOGRAPHIC_COST_QUANTIZE_PACK_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define LCQP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define LCQP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lcqp_pkg.sv]
`timescale 1ns / 1ps

package lcqp_pkg;

    // Fixed field widths.
    localparam int LOW_BOUND_W = 16;
    localparam int UB_W        = 31;
    localparam int ROB_W       = 32;
    localparam int ACC_W       = 64;
    localparam int USED_W      = 10;
    localparam int SLOT_W      = 4;
    localparam int SLOT_DEPTH  = 16;
    localparam int FLD_W       = 5;
    localparam int LEN_IN_W    = 16;

    localparam logic [LOW_BOUND_W-1:0] LOW_BOUND_RESET = 16'd7;
    localparam logic [USED_W-1:0]      USED_MAX        = 10'd1023;
    localparam logic [USED_W:0]        ACC_LIMIT       = 11'd64;

    // Request kinds.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_COST = 1'b1;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_ACC  = 5'b10000
    } lcqp_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_wr;
        logic capture;
        logic prep;
        logic mul;
        logic div_step;
        logic div_last;
        logic acc;
    } lcqp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic acc_blocked;
    } lcqp_sts_t;

    // Bit length of an interval count (number of bits up to the top set bit).
    function automatic logic [FLD_W-1:0] bit_len(input logic [LEN_IN_W-1:0] v);
        logic [FLD_W-1:0] n;
        n = '0;
        for (int i = 0; i < LEN_IN_W; i++)
        begin
            if (v[i])
            begin
                n = FLD_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

[src/lcqp_if.sv]
`timescale 1ns / 1ps

// Request channel: load items and cost items.
interface lcqp_req_if #(
    parameter int COUNT_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [3:0]            slot_index;
    logic [COUNT_BITS-1:0] interval_count;
    logic [30:0]           upper_bound;
    logic signed [31:0]    robustness;
    logic                  last_rule;

    modport source (output valid, req_type, slot_index, interval_count, upper_bound,
                    robustness, last_rule, input ready);
    modport sink (input valid, req_type, slot_index, interval_count, upper_bound,
                  robustness, last_rule, output ready);
endinterface

// Result channel: packed lexicographic cost.
interface lcqp_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] packed_cost;
    logic        bits_overflow;

    modport source (output valid, packed_cost, bits_overflow, input ready);
    modport sink (input valid, packed_cost, bits_overflow, output ready);
endinterface

// Configuration write channel for the low bound register.
interface lcqp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[src/lcqp_ctrl.sv]
`timescale 1ns / 1ps

module lcqp_ctrl #(
    parameter int COUNT_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_req_type,
    output logic               in_ready,
    input  lcqp_pkg::lcqp_sts_t sts,
    output lcqp_pkg::lcqp_cmd_t cmd
);

    localparam int CNT_W = $clog2(COUNT_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(COUNT_BITS - 1);

    lcqp_pkg::lcqp_state_t state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  in_fire;

    assign in_ready = (state_reg == lcqp_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    // Next state, step counter and commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            lcqp_pkg::ST_IDLE:
            begin
                if (in_fire && (in_req_type == lcqp_pkg::REQ_LOAD))
                begin
                    cmd.load_wr = 1'b1;
                end
                if (in_fire && (in_req_type == lcqp_pkg::REQ_COST))
                begin
                    cmd.capture = 1'b1;
                    state_next  = lcqp_pkg::ST_PREP;
                end
            end
            lcqp_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = sts.need_div ? lcqp_pkg::ST_MUL : lcqp_pkg::ST_ACC;
            end
            lcqp_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = CNT_LOAD;
                state_next = lcqp_pkg::ST_DIV;
            end
            lcqp_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    cmd.div_last = 1'b1;
                    state_next   = lcqp_pkg::ST_ACC;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            lcqp_pkg::ST_ACC:
            begin
                if (!sts.acc_blocked)
                begin
                    cmd.acc    = 1'b1;
                    state_next = lcqp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcqp_pkg::ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcqp_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[src/lcqp_dp.sv]
`timescale 1ns / 1ps

module lcqp_dp #(
    parameter int MAX_RULES  = 16,
    parameter int COUNT_BITS = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lcqp_pkg::lcqp_cmd_t                  cmd,
    output lcqp_pkg::lcqp_sts_t                  sts,
    input  logic [lcqp_pkg::SLOT_W-1:0]          slot_index,
    input  logic [COUNT_BITS-1:0]                interval_count,
    input  logic [lcqp_pkg::UB_W-1:0]            upper_bound,
    input  logic signed [lcqp_pkg::ROB_W-1:0]    robustness,
    input  logic                                 last_rule,
    input  logic                                 cfg_valid,
    input  logic [lcqp_pkg::LOW_BOUND_W-1:0]     cfg_data,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [lcqp_pkg::ACC_W-1:0]           packed_cost,
    output logic                                 bits_overflow
);

    localparam int UB_W  = lcqp_pkg::UB_W;
    localparam int DIV_W = UB_W + COUNT_BITS;
    localparam int POS_W = 7;
    localparam logic [POS_W-1:0] MAX_RULES_C = POS_W'(MAX_RULES);

    // Rule slot memories.
    logic [COUNT_BITS-1:0] cnt_mem [lcqp_pkg::SLOT_DEPTH];
    logic [UB_W-1:0]       ub_mem  [lcqp_pkg::SLOT_DEPTH];

    logic [COUNT_BITS-1:0]               cnt_rd_reg;
    logic [UB_W-1:0]                     ub_rd_reg;
    logic signed [lcqp_pkg::ROB_W-1:0]   rob_reg;
    logic                                last_reg;
    logic [lcqp_pkg::LOW_BOUND_W-1:0]    low_bound_reg;

    logic [UB_W-1:0]                     diff_reg, den_reg;
    logic [COUNT_BITS-1:0]               cm1_reg, bucket_reg, bucket_next;
    logic [lcqp_pkg::FLD_W-1:0]          width_reg;
    logic [DIV_W-1:0]                    rem_reg, rem_next, dvs_reg, dvs_next;
    logic [COUNT_BITS-1:0]               q_reg, q_next;

    logic [lcqp_pkg::ACC_W-1:0]          acc_reg, acc_next;
    logic [lcqp_pkg::USED_W-1:0]         used_reg, used_next;
    logic                                ovf_reg, ovf_next;
    logic [lcqp_pkg::SLOT_W-1:0]         pos_reg;
    logic [POS_W-1:0]                    pos_inc;

    logic                                out_valid_reg;
    logic [lcqp_pkg::ACC_W-1:0]          out_cost_reg;
    logic                                out_ovf_reg;

    logic signed [32:0]                  cost, lb_s, ub_s, diff_full;
    logic                                below, ge_ub, cnt_zero, cnt_one;
    logic [COUNT_BITS-1:0]               trivial_bucket;
    logic [DIV_W-1:0]                    product;
    logic                                ge;
    logic [lcqp_pkg::USED_W:0]           used_sum;

    // Slot memory write on a load beat, registered read at the rule position.
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            cnt_mem[slot_index] <= interval_count;
            ub_mem[slot_index]  <= upper_bound;
        end
        if (cmd.capture)
        begin
            cnt_rd_reg <= cnt_mem[pos_reg];
            ub_rd_reg  <= ub_mem[pos_reg];
            rob_reg    <= robustness;
            last_reg   <= last_rule;
        end
    end

    // Low bound register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_bound_reg <= lcqp_pkg::LOW_BOUND_RESET;
        end
        else if (cfg_valid)
        begin
            low_bound_reg <= cfg_data;
        end
    end

    // Cost is the exact negation of the robustness; compare against both bounds.
    always_comb
    begin
        cost      = -($signed({rob_reg[lcqp_pkg::ROB_W-1], rob_reg}));
        lb_s      = $signed({17'b0, low_bound_reg});
        ub_s      = $signed({2'b0, ub_rd_reg});
        diff_full = cost - lb_s;
        below     = cost < lb_s;
        ge_ub     = cost >= ub_s;
        cnt_zero  = (cnt_rd_reg == '0);
        cnt_one   = (cnt_rd_reg == COUNT_BITS'(1));
        priority if (below || cnt_zero)
        begin
            trivial_bucket = '0;
        end
        else if (cnt_one)
        begin
            trivial_bucket = COUNT_BITS'(1);
        end
        else
        begin
            trivial_bucket = cnt_rd_reg;
        end
    end

    assign sts.need_div    = !below && !cnt_zero && !cnt_one && !ge_ub;
    assign sts.acc_blocked = last_reg && out_valid_reg && !out_ready;

    // Scaled numerator and one restoring division step.
    assign product = DIV_W'(diff_reg) * DIV_W'(cm1_reg);

    always_comb
    begin
        ge          = rem_reg >= dvs_reg;
        rem_next    = ge ? (rem_reg - dvs_reg) : rem_reg;
        q_next      = (q_reg << 1) | COUNT_BITS'(ge);
        dvs_next    = dvs_reg >> 1;
        bucket_next = q_next + COUNT_BITS'(1);
    end

    // Operand preparation and division registers.
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            diff_reg   <= diff_full[UB_W-1:0];
            den_reg    <= ub_rd_reg - UB_W'(low_bound_reg);
            cm1_reg    <= cnt_rd_reg - COUNT_BITS'(1);
            bucket_reg <= trivial_bucket;
            width_reg  <= lcqp_pkg::bit_len(lcqp_pkg::LEN_IN_W'(cnt_rd_reg));
        end
        if (cmd.mul)
        begin
            rem_reg <= product;
            dvs_reg <= DIV_W'(den_reg) << (COUNT_BITS - 1);
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvs_reg <= dvs_next;
            q_reg   <= q_next;
        end
        if (cmd.div_last)
        begin
            bucket_reg <= bucket_next;
        end
    end

    // Shift the bucket into the accumulator and track the bits used.
    always_comb
    begin
        acc_next  = (acc_reg << width_reg) | lcqp_pkg::ACC_W'(bucket_reg);
        used_sum  = {1'b0, used_reg} + (lcqp_pkg::USED_W + 1)'(width_reg);
        ovf_next  = ovf_reg || (used_sum > lcqp_pkg::ACC_LIMIT);
        used_next = used_sum[lcqp_pkg::USED_W] ? lcqp_pkg::USED_MAX
                                               : used_sum[lcqp_pkg::USED_W-1:0];
        pos_inc   = POS_W'(pos_reg) + POS_W'(1);
    end

    // Evaluation state: accumulator, bit count, overflow flag and rule position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            used_reg <= '0;
            ovf_reg  <= 1'b0;
            pos_reg  <= '0;
        end
        else if (cmd.acc)
        begin
            if (last_reg)
            begin
                acc_reg  <= '0;
                used_reg <= '0;
                ovf_reg  <= 1'b0;
                pos_reg  <= '0;
            end
            else
            begin
                acc_reg  <= acc_next;
                used_reg <= used_next;
                ovf_reg  <= ovf_next;
                pos_reg  <= (pos_inc >= MAX_RULES_C) ? '0 : pos_inc[lcqp_pkg::SLOT_W-1:0];
            end
        end
    end

    // Output register holds one finished beat until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.acc && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc && last_reg)
        begin
            out_cost_reg <= acc_next;
            out_ovf_reg  <= ovf_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign packed_cost   = out_cost_reg;
    assign bits_overflow = out_ovf_reg;

endmodule

[src/lexicographic_cost_quantize_pack_unit.sv]
`timescale 1ns / 1ps

// Lexicographic cost quantizer and packer. A load beat (req_type 0) stores one rule
// slot's interval count and upper bound. A cost beat (req_type 1) takes the next
// rule's robustness in rulebook order, quantizes its negation into a bucket and
// shifts the bucket into a 64-bit accumulator, first rule most significant; the beat
// marked last_rule yields one result beat with the packed cost and an overflow flag,
// and starts the next evaluation. A cost beat whose bucket is settled by the bound
// compares is prepared and accumulated; otherwise it also passes through a multiply
// and a scaled division, which runs one quotient bit per cycle in a shared
// restoring divider; no new beat is taken until the current one is finished. A finished
// result waits in an output register while the next beats are accepted; a last-rule beat
// that finishes while the previous result is still waiting holds the block until that
// result is taken. The low bound register may be written at any time the block is idle
// and resets to 7 (about 0.0001).
module lexicographic_cost_quantize_pack_unit #(
    parameter int MAX_RULES  = 16,
    parameter int COUNT_BITS = 10
) (
    input  logic      clk,
    input  logic      rst_n,
    lcqp_req_if.sink   req,
    lcqp_res_if.source res,
    lcqp_cfg_if.sink   cfg
);

    lcqp_pkg::lcqp_cmd_t cmd;
    lcqp_pkg::lcqp_sts_t sts;

    assign cfg.ready = 1'b1;

    lcqp_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_req_type (req.req_type),
        .in_ready    (req.ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    lcqp_dp #(
        .MAX_RULES  (MAX_RULES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .slot_index     (req.slot_index),
        .interval_count (req.interval_count),
        .upper_bound    (req.upper_bound),
        .robustness     (req.robustness),
        .last_rule      (req.last_rule),
        .cfg_valid      (cfg.valid),
        .cfg_data       (cfg.data),
        .out_ready      (res.ready),
        .out_valid      (res.valid),
        .packed_cost    (res.packed_cost),
        .bits_overflow  (res.bits_overflow)
    );

endmodule

[src/lcqp_checker.sv]
`timescale 1ns / 1ps
`include "lexicographic_cost_quantize_pack_unit_assert.svh"

module lcqp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        req_type,
    input logic        res_valid,
    input logic        res_ready,
    input logic [63:0] packed_cost,
    input logic        bits_overflow
);

    logic        req_fire;
    logic        res_stall;
    logic [64:0] res_beat;

    assign req_fire  = req_valid && req_ready;
    assign res_stall = res_valid && !res_ready;
    assign res_beat  = {packed_cost, bits_overflow};

    // A stalled result beat keeps its value.
    `LCQP_ASSERT_NEXT(a_res_hold, res_stall, res_valid && $stable(res_beat), "result not held")

    // A cost beat occupies the block for at least the next cycle.
    `LCQP_ASSERT_NEXT(a_cost_busy, req_fire && req_type, !req_ready, "cost beat not busy")

    // A load beat completes in the cycle it is taken.
    `LCQP_ASSERT_NEXT(a_load_quick, req_fire && !req_type, req_ready, "load beat stalled")

    // A new result only follows a busy cycle of the cost datapath.
    `LCQP_ASSERT_NOW(a_res_origin, $rose(res_valid), !$past(req_ready), "result without cost")

endmodule

bind lexicographic_cost_quantize_pack_unit lcqp_checker u_lcqp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_type      (req.req_type),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .packed_cost   (res.packed_cost),
    .bits_overflow (res.bits_overflow)
);
